// ===== src/assert_macros.svh =====
// Assertion macros used by the stepper ramp core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif
`endif

// ===== src/str_pkg.sv =====
// Package with shared constants and types of the stepper ramp generator.
`timescale 1ns / 1ps
package str_pkg;
  localparam int MsWidth = 9;
  localparam int TpsWidth = 24;
  localparam int CntWidth = 24;
  localparam logic [MsWidth-1:0] MsReset = 9'd1;
  localparam logic [TpsWidth-1:0] TpsReset = 24'd15625;
  localparam logic [2:0] FuncStart = 3'd0;
  localparam logic [2:0] FuncTick = 3'd1;
  localparam logic [2:0] FuncSoft = 3'd2;
  localparam logic [2:0] FuncHard = 3'd3;
  localparam logic [2:0] FuncResume = 3'd4;
  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhAcc = 2'd1;
  localparam logic [1:0] PhCruise = 2'd2;
  localparam logic [1:0] PhDec = 2'd3;
  localparam logic CfgMs = 1'b0;
  localparam logic CfgTps = 1'b1;
  localparam logic [15:0] StartPeriod = 16'd100;
  localparam logic [15:0] PeriodMax = 16'hffff;
endpackage

// ===== src/str_sqrt.sv =====
// Bit-serial integer square root of n * 2^32, two radicand bits per cycle.
`timescale 1ns / 1ps
module str_sqrt
  import str_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [CntWidth-1:0] n_i,
  output logic                busy_o,
  output logic [27:0]         root_o
);
  // Radicand is 56 bits wide, so 28 result bits, one per cycle.
  logic [55:0] rad_q, rad_d;
  logic [29:0] rem_q, rem_d;
  logic [27:0] root_q, root_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [29:0] trial;

  // Restoring digit recurrence.
  always_comb begin
    rad_d = rad_q;
    rem_d = rem_q;
    root_d = root_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    trial = '0;
    if (start_i) begin
      rad_d = {n_i, 32'd0};
      rem_d = '0;
      root_d = '0;
      cnt_d = 5'd27;
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q[27:0], rad_q[55:54]} - {root_q, 2'b01};
      if (!trial[29] && ({rem_q[27:0], rad_q[55:54]} >= {root_q, 2'b01})) begin
        rem_d = trial;
        root_d = {root_q[26:0], 1'b1};
      end else begin
        rem_d = {rem_q[27:0], rad_q[55:54]};
        root_d = {root_q[26:0], 1'b0};
      end
      rad_d = {rad_q[53:0], 2'b00};
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q <= rad_d;
    rem_q <= rem_d;
    root_q <= root_d;
  end

  assign busy_o = busy_q;
  assign root_o = root_q;
endmodule

// ===== src/str_div.sv =====
// Bit-serial restoring divider with a 16-bit saturated quotient.
`timescale 1ns / 1ps
module str_div
  import str_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [51:0] num_i,
  input  logic [27:0] den_i,
  output logic        busy_o,
  output logic [15:0] quot_o
);
  logic [51:0] num_q, num_d;
  logic [28:0] rem_q, rem_d;
  logic [27:0] den_q, den_d;
  logic [15:0] quot_q, quot_d;
  logic        sat_q, sat_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [28:0] sh;

  // One quotient bit per cycle; any set bit above bit 15 saturates.
  always_comb begin
    num_d = num_q;
    rem_d = rem_q;
    den_d = den_q;
    quot_d = quot_q;
    sat_d = sat_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    sh = {rem_q[27:0], num_q[51]};
    if (start_i) begin
      num_d = num_i;
      den_d = den_i;
      rem_d = '0;
      quot_d = '0;
      sat_d = (den_i == '0);
      cnt_d = 6'd51;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[50:0], 1'b0};
      if (sh >= {1'b0, den_q}) begin
        rem_d = sh - {1'b0, den_q};
        quot_d = {quot_q[14:0], 1'b1};
        if (cnt_q > 6'd15) begin
          sat_d = 1'b1;
        end
      end else begin
        rem_d = sh;
        quot_d = {quot_q[14:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
    quot_q <= quot_d;
    sat_q <= sat_d;
  end

  assign busy_o = busy_q;
  assign quot_o = sat_q ? PeriodMax : quot_q;
endmodule

// ===== src/str_mul.sv =====
// Shift-and-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module str_mul
  import str_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [27:0]         a_i,
  input  logic [TpsWidth-1:0] b_i,
  output logic                busy_o,
  output logic [51:0]         prod_o
);
  logic [51:0]         acc_q, acc_d;
  logic [51:0]         a_q, a_d;
  logic [TpsWidth-1:0] b_q, b_d;
  logic [4:0]          cnt_q, cnt_d;
  logic                busy_q, busy_d;

  // Add the shifted multiplicand for every set multiplier bit.
  always_comb begin
    acc_d = acc_q;
    a_d = a_q;
    b_d = b_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      acc_d = '0;
      a_d = {24'd0, a_i};
      b_d = b_i;
      cnt_d = 5'(TpsWidth - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_d = acc_q + a_q;
      end
      a_d = {a_q[50:0], 1'b0};
      b_d = {1'b0, b_q[TpsWidth-1:1]};
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q <= a_d;
    b_q <= b_d;
  end

  assign busy_o = busy_q;
  assign prod_o = acc_q;
endmodule

// ===== src/stepper_trapezoid_ramp_core.sv =====
// Top level of the trapezoidal stepper ramp generator.
//
// Usage: command words enter on in_valid_i/in_ready_o with func_i and the start
// fields; one result word leaves on out_valid_o/out_ready_i for every command.
// Configuration writes (index 0 microstep factor, index 1 ticks per second) use
// cfg_valid_i/cfg_ready_o and are taken only while no command is in flight.
// Start, stop, resume and idle ticks go from the decode state straight to the
// output state. A cruise tick runs one 52-step serial divide. A ramp tick runs
// three 28-step serial square roots, a 24-step serial multiply and a 52-step
// serial divide one after another in shared units. A tick re-enters the decode
// state for each finished phase that it passes through.
// One command is worked at a time; in_ready_o is low until the result word
// has been taken. A stalled receiver holds the result in the output register.
// Reset clears the motion state, restores the register defaults and leaves
// the block idle and ready.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module stepper_trapezoid_ramp_core
  import str_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          func_i,
  input  logic [15:0]         step_count_i,
  input  logic [15:0]         velocity_i,
  input  logic                clockwise_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                step_pulse_o,
  output logic                period_valid_o,
  output logic [15:0]         next_period_o,
  output logic                direction_cw_o,
  output logic signed [31:0]  position_o,
  output logic [1:0]          phase_o,
  output logic                done_res_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [TpsWidth-1:0] cfg_data_i
);
  // Sequencer codes.
  localparam logic [3:0] SIdle = 4'd0;
  localparam logic [3:0] SDecode = 4'd1;
  localparam logic [3:0] SRootA = 4'd2;
  localparam logic [3:0] SRootB = 4'd3;
  localparam logic [3:0] SRootC = 4'd4;
  localparam logic [3:0] SMul = 4'd5;
  localparam logic [3:0] SDiv = 4'd6;
  localparam logic [3:0] SOut = 4'd7;
  localparam logic [3:0] SStartMul = 4'd8;

  logic [3:0] st_q, st_d;
  logic [MsWidth-1:0]  ms_q;
  logic [TpsWidth-1:0] tps_q;
  logic [1:0]  ph_q, ph_d;
  logic [CntWidth-1:0] seq_q, seq_d, acc_q, acc_d, cru_q, cru_d, dec_q, dec_d;
  logic [14:0] rb_q, rb_d;
  logic [15:0] vel_q, vel_d;
  logic        dir_q, dir_d;
  logic [31:0] pos_q, pos_d;
  logic [2:0]  func_q;
  logic [15:0] cnt_in_q, vel_in_q;
  logic        cw_in_q;
  logic        pulse_q, pulse_d, pv_q, pv_d, done_q, done_d;
  logic [15:0] per_q, per_d;
  logic        cruise_div_q, cruise_div_d;
  logic [27:0] ra_q, ra_d, rb2_q, rb2_d;
  logic [27:0] rc_q, rc_d;
  logic        ovalid_q, ovalid_d;

  // Serial units.
  logic        sq_start, sq_busy, mu_start, mu_busy, dv_start, dv_busy;
  logic [CntWidth-1:0] sq_n;
  logic [27:0] sq_root;
  logic [51:0] mu_prod, dv_num;
  logic [27:0] dv_den;
  logic [15:0] dv_quot;
  logic [24:0] total_w;
  logic [CntWidth-1:0] total;
  logic [CntWidth-1:0] lo_arg;
  logic        started_q, started_d;

  str_sqrt u_sqrt (.clk_i, .rst_ni, .start_i(sq_start), .n_i(sq_n),
                   .busy_o(sq_busy), .root_o(sq_root));
  str_mul u_mul (.clk_i, .rst_ni, .start_i(mu_start), .a_i(ra_q - rb2_q), .b_i(tps_q),
                 .busy_o(mu_busy), .prod_o(mu_prod));
  str_div u_div (.clk_i, .rst_ni, .start_i(dv_start), .num_i(dv_num), .den_i(dv_den),
                 .busy_o(dv_busy), .quot_o(dv_quot));

  assign dv_num = cruise_div_q ? {28'd0, tps_q} : mu_prod;
  assign dv_den = cruise_div_q ? {12'd0, vel_q} : rc_q;
  assign lo_arg = (ph_q == PhAcc) ? seq_q : dec_q - 24'd1 - seq_q;

  // Step count times microstep factor, 16x9 bits, saturated to 24 bits.
  always_comb begin
    total_w = 25'(cnt_in_q * ms_q);
    total = total_w[24] ? {CntWidth{1'b1}} : total_w[CntWidth-1:0];
  end

  assign in_ready_o = (st_q == SIdle) && !ovalid_q;
  assign cfg_ready_o = (st_q == SIdle) && !ovalid_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q <= MsReset;
      tps_q <= TpsReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CfgMs) begin
        ms_q <= cfg_data_i[MsWidth-1:0];
      end else begin
        tps_q <= cfg_data_i;
      end
    end
  end

  // Command capture.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      func_q <= func_i;
      cnt_in_q <= step_count_i;
      vel_in_q <= velocity_i;
      cw_in_q <= clockwise_i;
    end
  end

  // Sequencer: decodes the command, walks finished phases, runs the units.
  always_comb begin
    st_d = st_q; ph_d = ph_q; seq_d = seq_q; acc_d = acc_q; cru_d = cru_q;
    dec_d = dec_q; rb_d = rb_q; vel_d = vel_q; dir_d = dir_q; pos_d = pos_q;
    pulse_d = pulse_q; pv_d = pv_q; per_d = per_q; done_d = done_q;
    cruise_div_d = cruise_div_q; ra_d = ra_q; rb2_d = rb2_q; rc_d = rc_q;
    ovalid_d = ovalid_q; started_d = 1'b0;
    sq_start = 1'b0; sq_n = seq_q + 24'd1; mu_start = 1'b0; dv_start = 1'b0;
    case (st_q)
      SIdle: begin
        if (out_valid_o && out_ready_i) begin
          ovalid_d = 1'b0;
        end
        if (in_valid_i && in_ready_o) begin
          st_d = SDecode;
          pulse_d = 1'b0; pv_d = 1'b0; per_d = '0; done_d = 1'b0;
          ovalid_d = 1'b0;
        end
      end
      SDecode: begin
        st_d = SOut;
        case (func_q)
          FuncStart: begin
            if (ph_q == PhIdle) begin
              vel_d = vel_in_q;
              rb_d = vel_in_q[15:1];
              if (total < {8'd0, vel_in_q[15:1], 1'b0}) begin
                acc_d = {1'b0, total[CntWidth-1:1]};
                dec_d = total - {1'b0, total[CntWidth-1:1]};
                cru_d = '0;
              end else begin
                acc_d = {9'd0, vel_in_q[15:1]};
                dec_d = {9'd0, vel_in_q[15:1]};
                cru_d = total - {8'd0, vel_in_q[15:1], 1'b0};
              end
              dir_d = cw_in_q;
              ph_d = PhAcc;
              seq_d = '0;
              pv_d = 1'b1;
              per_d = StartPeriod;
            end
          end
          FuncTick: begin
            st_d = SDecode;
            case (ph_q)
              PhAcc: begin
                if (seq_q >= acc_q) begin
                  seq_d = '0; ph_d = PhCruise;
                end else begin
                  st_d = SRootA; sq_start = 1'b1; sq_n = seq_q + 24'd1;
                end
              end
              PhCruise: begin
                if (seq_q >= cru_q) begin
                  seq_d = '0; ph_d = PhDec;
                end else begin
                  st_d = SDiv; cruise_div_d = 1'b1; started_d = 1'b1;
                end
              end
              PhDec: begin
                if (seq_q >= dec_q) begin
                  seq_d = '0; ph_d = PhIdle; done_d = 1'b1; st_d = SOut;
                end else begin
                  st_d = SRootA; sq_start = 1'b1; sq_n = dec_q - seq_q;
                end
              end
              default: st_d = SOut;
            endcase
          end
          FuncSoft: begin
            if (ph_q != PhIdle) cru_d = '0;
          end
          FuncHard: begin
            if (ph_q != PhIdle) begin
              seq_d = '0; ph_d = PhIdle;
            end
          end
          FuncResume: begin
            if (ph_q == PhDec) begin
              ph_d = PhAcc; seq_d = acc_q - seq_q;
            end
          end
          default: st_d = SOut;
        endcase
      end
      SRootA: begin
        if (!sq_busy) begin
          ra_d = sq_root; st_d = SRootB; sq_start = 1'b1; sq_n = lo_arg;
        end
      end
      SRootB: begin
        if (!sq_busy) begin
          rb2_d = sq_root; st_d = SRootC; sq_start = 1'b1; sq_n = {9'd0, rb_q};
        end
      end
      SRootC: begin
        if (!sq_busy) begin
          rc_d = sq_root; st_d = SStartMul;
        end
      end
      SStartMul: begin
        mu_start = 1'b1; st_d = SMul;
      end
      SMul: begin
        if (!mu_busy) begin
          st_d = SDiv; cruise_div_d = 1'b0; started_d = 1'b1;
        end
      end
      SDiv: begin
        dv_start = started_q;
        if (!started_q && !dv_busy) begin
          pulse_d = 1'b1; pv_d = 1'b1; per_d = dv_quot;
          pos_d = dir_q ? pos_q + 32'd1 : pos_q - 32'd1;
          seq_d = seq_q + 24'd1;
          st_d = SOut;
        end
      end
      SOut: begin
        ovalid_d = 1'b1; st_d = SIdle;
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; ph_q <= PhIdle; seq_q <= '0; acc_q <= '0; cru_q <= '0;
      dec_q <= '0; rb_q <= '0; vel_q <= '0; dir_q <= 1'b0; pos_q <= '0;
      ovalid_q <= 1'b0; started_q <= 1'b0;
    end else begin
      st_q <= st_d; ph_q <= ph_d; seq_q <= seq_d; acc_q <= acc_d; cru_q <= cru_d;
      dec_q <= dec_d; rb_q <= rb_d; vel_q <= vel_d; dir_q <= dir_d; pos_q <= pos_d;
      ovalid_q <= ovalid_d; started_q <= started_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pulse_q <= pulse_d; pv_q <= pv_d; per_q <= per_d; done_q <= done_d;
    cruise_div_q <= cruise_div_d; ra_q <= ra_d; rb2_q <= rb2_d; rc_q <= rc_d;
  end

  assign out_valid_o = ovalid_q;
  assign step_pulse_o = pulse_q;
  assign period_valid_o = pv_q;
  assign next_period_o = per_q;
  assign direction_cw_o = dir_q;
  assign position_o = pos_q;
  assign phase_o = ph_q;
  assign done_res_o = done_q;

  // A result word is only shown while the sequencer waits for the next command.
  `ASSERT_IMPL(a_out_idle, out_valid_o |-> st_q == SIdle, "result outside idle")
  // A pulse always comes with a new period.
  `ASSERT_IMPL(a_pulse_pv, out_valid_o && step_pulse_o |-> period_valid_o, "pulse no period")
  // Completion leaves the motor idle.
  `ASSERT_IMPL(a_done_idle, out_valid_o && done_res_o |-> phase_o == PhIdle, "done not idle")
  // No command is taken while a result waits.
  `ASSERT_NEVER(a_no_overlap, out_valid_o && !out_ready_i && in_valid_i && in_ready_o,
                "overlap")
endmodule

// ===== verif/stepper_ramp_checker.sv =====
// Checker that predicts and compares every result word of the stepper ramp generator.
`timescale 1ns / 1ps
module stepper_ramp_checker
  import str_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [2:0]          func_i,
  input  logic [15:0]         step_count_i,
  input  logic [15:0]         velocity_i,
  input  logic                clockwise_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic                step_pulse_i,
  input  logic                period_valid_i,
  input  logic [15:0]         next_period_i,
  input  logic                direction_cw_i,
  input  logic signed [31:0]  position_i,
  input  logic [1:0]          phase_i,
  input  logic                done_res_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic                cfg_index_i,
  input  logic [TpsWidth-1:0] cfg_data_i,
  output int                  fail_cnt_o,
  output int                  pending_o,
  output int                  words_seen_o,
  output int                  pulses_seen_o,
  output int                  moves_done_o
);

  typedef struct packed {
    logic               pulse;
    logic               pvalid;
    logic [15:0]        period;
    logic               dir;
    logic signed [31:0] pos;
    logic [1:0]         ph;
    logic               done;
  } motion_word_t;

  localparam logic [23:0] Mask24 = 24'hffffff;

  motion_word_t        motion_q[$];

  // Model of the motion state and the two registers.
  logic [MsWidth-1:0]  ms_factor;
  logic [TpsWidth-1:0] tick_rate;
  logic [1:0]          ph_s;
  logic [23:0]         seq_s;
  logic [14:0]         ramp_s;
  logic [23:0]         acc_s, cru_s, dec_s;
  logic [15:0]         vel_s;
  logic                dir_s;
  logic [31:0]         pos_s;

  assign pending_o = motion_q.size();

  // Bitwise integer square root.
  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Square root in unsigned 16.16 format.
  function automatic longint unsigned root_q16(int unsigned n);
    longint unsigned wide;
    wide = longint'(n) << 32;
    return int_sqrt(wide);
  endfunction

  function automatic logic [15:0] clamp_div(longint unsigned num, longint unsigned den);
    longint unsigned q;
    if (den == 0) return PeriodMax;
    q = num / den;
    return (q > 65535) ? PeriodMax : q[15:0];
  endfunction

  function automatic logic [15:0] ramp_period(int unsigned hi, int unsigned lo);
    longint unsigned diff;
    diff = root_q16(hi) - root_q16(lo);
    return clamp_div(longint'(tick_rate) * diff, root_q16(32'(ramp_s)));
  endfunction

  function automatic void take_step();
    pos_s = dir_s ? pos_s + 32'd1 : pos_s - 32'd1;
  endfunction

  // Works out the result word of one command and advances the model.
  function automatic motion_word_t predict_motion(logic [2:0] f, logic [15:0] cnt,
                                                  logic [15:0] vel, logic cw);
    motion_word_t    w;
    longint unsigned total;
    logic [23:0]     t;
    w = '0;
    case (f)
      FuncStart: begin
        if (ph_s == PhIdle) begin
          total = longint'(cnt) * longint'(ms_factor);
          if (total > 64'(Mask24)) total = 64'(Mask24);
          t      = total[23:0];
          vel_s  = vel;
          ramp_s = vel[15:1];
          if (32'(t) < 2 * 32'(ramp_s)) begin
            acc_s = t >> 1;
            dec_s = t - (t >> 1);
            cru_s = '0;
          end else begin
            acc_s = 24'(ramp_s);
            dec_s = 24'(ramp_s);
            cru_s = t - 24'(2 * 32'(ramp_s));
          end
          dir_s    = cw;
          ph_s     = PhAcc;
          seq_s    = '0;
          w.pvalid = 1'b1;
          w.period = StartPeriod;
        end
      end
      FuncTick: begin
        // Finished phases are passed through within the same tick.
        if (ph_s == PhAcc) begin
          if (seq_s >= acc_s) begin
            seq_s = '0;
            ph_s  = PhCruise;
          end else begin
            w.pulse  = 1'b1;
            w.pvalid = 1'b1;
            w.period = ramp_period(32'(seq_s) + 1, 32'(seq_s));
            take_step();
            seq_s = seq_s + 24'd1;
          end
        end
        if (ph_s == PhCruise) begin
          if (seq_s >= cru_s) begin
            seq_s = '0;
            ph_s  = PhDec;
          end else begin
            w.pulse  = 1'b1;
            w.pvalid = 1'b1;
            w.period = clamp_div(64'(tick_rate), 64'(vel_s));
            take_step();
            seq_s = seq_s + 24'd1;
          end
        end
        if (ph_s == PhDec) begin
          if (seq_s >= dec_s) begin
            seq_s  = '0;
            ph_s   = PhIdle;
            w.done = 1'b1;
          end else begin
            w.pulse  = 1'b1;
            w.pvalid = 1'b1;
            w.period = ramp_period(32'(dec_s) - 32'(seq_s), 32'(dec_s) - 1 - 32'(seq_s));
            take_step();
            seq_s = seq_s + 24'd1;
          end
        end
      end
      FuncSoft: begin
        if (ph_s != PhIdle) cru_s = '0;
      end
      FuncHard: begin
        if (ph_s != PhIdle) begin
          seq_s = '0;
          ph_s  = PhIdle;
        end
      end
      FuncResume: begin
        // A resume during deceleration climbs back up the ramp.
        if (ph_s == PhDec) begin
          ph_s  = PhAcc;
          seq_s = acc_s - seq_s;
        end
      end
      default: ;
    endcase
    w.dir = dir_s;
    w.pos = pos_s;
    w.ph  = ph_s;
    return w;
  endfunction

  function automatic void report(string what, longint exp_v, longint act_v);
    $display("%0t: mismatch in %s: expected %0d, actual %0d", $time, what, exp_v, act_v);
    fail_cnt_o++;
  endfunction

  // Watch the three channels at each rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    motion_word_t e;
    if (!rst_ni) begin
      ms_factor = MsReset;
      tick_rate = TpsReset;
      ph_s  = PhIdle;
      seq_s = '0;
      ramp_s = '0;
      acc_s = '0;
      cru_s = '0;
      dec_s = '0;
      vel_s = '0;
      dir_s = 1'b0;
      pos_s = '0;
      motion_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CfgMs) ms_factor = cfg_data_i[MsWidth-1:0];
        else tick_rate = cfg_data_i;
      end
      if (in_valid_i && in_ready_i)
        motion_q.push_back(predict_motion(func_i, step_count_i, velocity_i, clockwise_i));
      if (out_valid_i && out_ready_i) begin
        words_seen_o++;
        if (step_pulse_i) pulses_seen_o++;
        if (done_res_i) moves_done_o++;
        if (motion_q.size() == 0) begin
          $display("%0t: result word with nothing expected", $time);
          fail_cnt_o++;
        end else begin
          e = motion_q.pop_front();
          if (step_pulse_i !== e.pulse) report("step_pulse", e.pulse, step_pulse_i);
          if (period_valid_i !== e.pvalid) report("period_valid", e.pvalid, period_valid_i);
          if (next_period_i !== e.period) report("next_period", e.period, next_period_i);
          if (direction_cw_i !== e.dir) report("direction_cw", e.dir, direction_cw_i);
          if (position_i !== e.pos) report("position", e.pos, position_i);
          if (phase_i !== e.ph) report("phase", e.ph, phase_i);
          if (done_res_i !== e.done) report("done_res", e.done, done_res_i);
        end
      end
    end
  end

  initial begin
    fail_cnt_o    = 0;
    words_seen_o  = 0;
    pulses_seen_o = 0;
    moves_done_o  = 0;
  end

endmodule

// ===== verif/tb_stepper_trapezoid_ramp_core.sv =====
// Testbench top that drives commands and registers into the stepper ramp generator.
`timescale 1ns / 1ps
module tb_stepper_trapezoid_ramp_core;
  import str_pkg::*;

  localparam int CycleLimit = 2000000;
  localparam int RandomWords = 1000;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i, in_ready_o;
  logic [2:0]          func_i;
  logic [15:0]         step_count_i, velocity_i;
  logic                clockwise_i;
  logic                out_valid_o, out_ready_i;
  logic                step_pulse_o, period_valid_o, direction_cw_o, done_res_o;
  logic [15:0]         next_period_o;
  logic signed [31:0]  position_o;
  logic [1:0]          phase_o;
  logic                cfg_valid_i, cfg_ready_o, cfg_index_i;
  logic [TpsWidth-1:0] cfg_data_i;

  int fail_cnt, pending, words_seen, pulses_seen, moves_done;
  int sent, cycles;

  stepper_trapezoid_ramp_core dut (.*);

  stepper_ramp_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .func_i, .step_count_i, .velocity_i, .clockwise_i,
    .out_valid_i(out_valid_o), .out_ready_i, .step_pulse_i(step_pulse_o),
    .period_valid_i(period_valid_o), .next_period_i(next_period_o),
    .direction_cw_i(direction_cw_o), .position_i(position_o), .phase_i(phase_o),
    .done_res_i(done_res_o), .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i,
    .cfg_data_i, .fail_cnt_o(fail_cnt), .pending_o(pending), .words_seen_o(words_seen),
    .pulses_seen_o(pulses_seen), .moves_done_o(moves_done)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Cycle counter with a hard limit on the run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Send one command word after a random gap; valid stays high across back-to-back words.
  task automatic send_cmd(logic [2:0] f, logic [15:0] cnt, logic [15:0] vel, logic cw);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    func_i       <= f;
    step_count_i <= cnt;
    velocity_i   <= vel;
    clockwise_i  <= cw;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  // Lower valid and wait until every expected word has been taken.
  task automatic settle();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [TpsWidth-1:0] val);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i) cfg_valid_i <= 1'b0;
  endtask

  // One move: a start, a run of ticks that need not finish it, with stray commands mixed in.
  task automatic random_move(int ms);
    int          cmax, nticks, roll;
    logic [15:0] cnt, vel;
    logic [2:0]  f;
    bit          wild;
    wild = ($urandom_range(0, 19) == 0);
    cmax = (ms > 8 || ms == 0) ? 2 : 25;
    cnt  = wild ? 16'($urandom) : 16'($urandom_range(0, cmax));
    vel  = wild ? 16'($urandom) : 16'($urandom_range(0, 40));
    send_cmd(FuncStart, cnt, vel, 1'($urandom));
    nticks = wild ? 3 : ((cnt * ms + 3 > 80) ? 80 : cnt * ms + 3);
    for (int i = 0; i < nticks; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) f = FuncSoft;
      else if (roll < 11) f = FuncHard;
      else if (roll < 17) f = FuncResume;
      else if (roll < 20) f = 3'($urandom_range(5, 7));
      else if (roll < 23) f = FuncStart;
      else f = FuncTick;
      send_cmd(f, 16'($urandom), 16'($urandom), 1'($urandom));
    end
    if (wild) send_cmd(FuncHard, '0, '0, 1'b0);
  endtask

  // Receiver: random stalls per word, and one long hold-off to back up the block.
  initial begin
    int g;
    int taken;
    out_ready_i = 1'b0;
    taken = 0;
    @(posedge rst_ni);
    forever begin
      g = (taken == 150) ? 400 : $urandom_range(0, 3);
      if (g > 0) begin
        @(negedge clk_i) out_ready_i <= 1'b0;
        repeat (g - 1) @(negedge clk_i);
      end
      @(negedge clk_i) out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
    end
  end

  initial begin
    int ms_set[8]  = '{1, 4, 256, 0, 511, 2, 1, 3};
    int tps_set[8] = '{15625, 1000000, 16777215, 1, 100, 0, 16777215, 250000};
    cycles = 0;
    sent = 0;
    in_valid_i = 1'b0;
    func_i = FuncTick;
    step_count_i = '0;
    velocity_i = '0;
    clockwise_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgMs;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Directed part at the reset register values.
    send_cmd(FuncTick, '0, '0, 1'b0);
    send_cmd(FuncStart, 16'd3, 16'd4, 1'b1);
    send_cmd(FuncStart, 16'd9, 16'd9, 1'b0);
    send_cmd(FuncTick, '0, '0, 1'b0);
    send_cmd(FuncResume, '0, '0, 1'b0);
    send_cmd(FuncSoft, '0, '0, 1'b0);
    repeat (3) send_cmd(FuncTick, '0, '0, 1'b0);
    send_cmd(FuncResume, '0, '0, 1'b0);
    repeat (5) send_cmd(FuncTick, '0, '0, 1'b0);
    send_cmd(FuncStart, 16'hffff, 16'hffff, 1'b0);
    send_cmd(FuncTick, '0, '0, 1'b0);
    send_cmd(FuncHard, '0, '0, 1'b0);
    send_cmd(FuncSoft, '0, '0, 1'b0);
    send_cmd(3'd5, '0, '0, 1'b0);
    send_cmd(3'd6, '0, '0, 1'b0);
    send_cmd(3'd7, 16'hffff, 16'hffff, 1'b1);
    send_cmd(FuncStart, 16'd4, 16'd0, 1'b1);
    repeat (3) send_cmd(FuncTick, '0, '0, 1'b0);
    send_cmd(FuncHard, '0, '0, 1'b0);

    // Random moves, one register setting per phase.
    for (int p = 0; p < 8; p++) begin
      settle();
      write_reg(CfgMs, TpsWidth'(ms_set[p]));
      write_reg(CfgTps, TpsWidth'(tps_set[p]));
      while (sent < 25 + (p + 1) * (RandomWords / 8)) random_move(ms_set[p] & 511);
      send_cmd(FuncHard, '0, '0, 1'b0);
    end

    settle();
    repeat (200) @(posedge clk_i);
    $display("Run covered %0d command words over 8 register settings in %0d cycles.",
             sent, cycles);
    $display("Results checked: %0d words, %0d step pulses, %0d completed moves.",
             words_seen, pulses_seen, moves_done);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== stepper_trapezoid_ramp_core.f =====
+incdir+src
src/str_pkg.sv
src/str_sqrt.sv
src/str_div.sv
src/str_mul.sv
src/stepper_trapezoid_ramp_core.sv
verif/stepper_ramp_checker.sv
verif/tb_stepper_trapezoid_ramp_core.sv
